FILE: hdl/b2bcd_pkg.sv
// Shared constants and types of the binary to packed BCD converter.
// Depends on nothing. It is compiled before every other file of the block.
package b2bcd_pkg;

    // Widths of the item fields and of the internal state.
    localparam int VALUE_W    = 64;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 20;
    localparam int MAX_BYTES  = NUM_DIGITS / 2;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int SHIFT_W    = 7;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Number of shift steps in one conversion.
    localparam logic [SHIFT_W-1:0] SHIFT_STEPS = SHIFT_W'(VALUE_W);

    // Register indexes, taken from paddr[2].
    localparam logic REG_BYTE_COUNT = 1'b0;
    localparam logic REG_SWAP_ORDER = 1'b1;

    // All digits of one conversion, least significant digit in the low nibble.
    typedef logic [NUM_DIGITS*DIGIT_W-1:0] t_digits;

    // Control shared by every digit cell.
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

    // Hand-off of a finished conversion to the output stage.
    typedef struct packed {
        logic               load;
        logic [COUNT_W-1:0] count;
        logic               swap;
    } t_load;

endpackage

FILE: hdl/b2bcd_in_if.sv
// Input channel of the converter: one binary value per item.
// Depends on b2bcd_pkg for the value width.
interface b2bcd_in_if;
    logic                          valid;
    logic                          ready;
    logic [b2bcd_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: hdl/b2bcd_out_if.sv
// Output channel of the converter: one packed BCD byte per item.
// Depends on b2bcd_pkg for the byte width.
interface b2bcd_out_if;
    logic                         valid;
    logic                         ready;
    logic [b2bcd_pkg::BYTE_W-1:0] bcd_byte;
    logic                         last;

    modport source (output valid, output bcd_byte, output last, input ready);
    modport sink   (input valid, input bcd_byte, input last, output ready);
endinterface

FILE: hdl/binary_to_packed_bcd_core.sv
// Top level of the 64-bit binary to packed BCD converter.
// Depends on b2bcd_pkg, both channel interfaces, b2bcd_cell and b2bcd_out.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------
//  i_in     | in        | valid / ready      | value (64 bits)
//  o_out    | out       | valid / ready      | bcd_byte (8 bits), last
//  APB      | in        | psel, penable, ... | byte_count, swap_order
//
// From acceptance to its first byte, a value goes through 64 shift steps in
// the chain of 20 digit cells, one value bit per step, and one hand-off to the output stage.
// The next value is accepted as the finished digits move to the output stage,
// so the chain holds one value at a time while the output stage sends the bytes of the one before.
// Reset is synchronous and active low; it empties the chain and the output stage.
// A stalled output holds its byte; the chain then waits with its digits.
module binary_to_packed_bcd_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    b2bcd_in_if.sink                        i_in,
    b2bcd_out_if.source                     o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [b2bcd_pkg::PADDR_W-1:0]   paddr,
    input  logic [b2bcd_pkg::PDATA_W-1:0]   pwdata,
    output logic [b2bcd_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);
    import b2bcd_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic               r_swap;
    logic               r_busy;
    logic               n_busy;
    logic [SHIFT_W-1:0] r_steps;
    logic [SHIFT_W-1:0] n_steps;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic               w_in_fire;
    logic               w_done;
    logic               w_free;
    logic               w_handoff;
    logic [COUNT_W-1:0] w_n;
    logic               w_wr;
    t_cell_ctrl         w_ctrl;
    t_load              w_load;
    t_digits            w_digits;
    logic [NUM_DIGITS:0] w_carry;

    // Configuration registers; the register is chosen by paddr[2].
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(MAX_BYTES);
            r_swap  <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_BYTE_COUNT: r_count <= pwdata[COUNT_W-1:0];
                REG_SWAP_ORDER: r_swap  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BYTE_COUNT: prdata = {{(PDATA_W-COUNT_W){1'b0}}, r_count};
            REG_SWAP_ORDER: prdata = {{(PDATA_W-1){1'b0}}, r_swap};
            default:        prdata = '0;
        endcase
    end

    // Byte count saturates at the number of bytes the chain can fill.
    assign w_n = (r_count > COUNT_W'(MAX_BYTES)) ? COUNT_W'(MAX_BYTES) : r_count;

    // Sequencing of the chain: load, 64 shift steps, then hand-off.
    assign w_done     = r_busy && (r_steps == SHIFT_STEPS);
    assign w_handoff  = w_done && w_free;
    assign i_in.ready = !r_busy || w_handoff;
    assign w_in_fire  = i_in.valid && i_in.ready;

    assign w_ctrl.clear = w_in_fire;
    assign w_ctrl.shift = r_busy && !w_done;

    always_comb begin
        n_busy  = r_busy;
        n_steps = r_steps;
        n_value = r_value;
        if (w_in_fire) begin
            n_busy  = 1'b1;
            n_steps = '0;
            n_value = i_in.value;
        end else if (w_handoff) begin
            n_busy = 1'b0;
        end else if (w_ctrl.shift) begin
            n_steps = r_steps + SHIFT_W'(1);
            n_value = {r_value[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_busy  <= n_busy;
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Chain of digit cells; the value's top bit enters the least significant cell.
    assign w_carry[0] = r_value[VALUE_W-1];

    for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_cells
        b2bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_carry (w_carry[d]),
            .o_carry (w_carry[d+1]),
            .o_digit (w_digits[d*DIGIT_W +: DIGIT_W])
        );
    end

    // Output stage takes the finished digits together with the settings.
    assign w_load.load  = w_handoff;
    assign w_load.count = w_n;
    assign w_load.swap  = r_swap;

    b2bcd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_digits (w_digits),
        .o_free   (w_free),
        .o_out    (o_out)
    );

    // A new item always starts the chain from step zero.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_busy && r_steps == '0))
        else $error("chain did not restart on a new item");

    // The step counter never runs past the value width.
    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= SHIFT_STEPS)
        else $error("shift step counter overran");

    // Every byte sent holds two valid decimal digits.
    a_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.bcd_byte[3:0] <= 4'd9 && o_out.bcd_byte[7:4] <= 4'd9))
        else $error("output byte is not packed BCD");

    // Digits move on only after all shift steps are done.
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_handoff |-> (r_steps == SHIFT_STEPS))
        else $error("hand-off before the conversion finished");

endmodule

FILE: hdl/b2bcd_cell.sv
// One decimal digit of the shift-and-add-3 chain.
// Depends on b2bcd_pkg for the digit width and the cell control struct.
module b2bcd_cell (
    input  logic                          i_clk,
    input  b2bcd_pkg::t_cell_ctrl         i_ctrl,
    input  logic                          i_carry,
    output logic                          o_carry,
    output logic [b2bcd_pkg::DIGIT_W-1:0] o_digit
);
    import b2bcd_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    // A digit of five or more gets three added, so that doubling carries.
    assign w_adj   = (r_digit >= DIGIT_W'(5)) ? r_digit + DIGIT_W'(3) : r_digit;
    assign o_carry = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    // Clear on a new item, otherwise shift in the bit from the lower cell.
    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.shift) begin
            n_digit = {w_adj[DIGIT_W-2:0], i_carry};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

FILE: hdl/b2bcd_out.sv
// Output stage: holds the digits of one finished conversion and sends its bytes.
// Depends on b2bcd_pkg and on the b2bcd_out_if interface.
module b2bcd_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  b2bcd_pkg::t_load      i_load,
    input  b2bcd_pkg::t_digits    i_digits,
    output logic                  o_free,
    b2bcd_out_if.source           o_out
);
    import b2bcd_pkg::*;

    logic               r_active;
    logic               n_active;
    logic [COUNT_W-1:0] r_idx;
    logic [COUNT_W-1:0] n_idx;
    logic [COUNT_W-1:0] r_n;
    logic               r_swap;
    t_digits            r_digits;
    logic [COUNT_W-1:0] w_pair;
    logic               w_last;
    logic               w_fire;
    logic [BYTE_W-1:0]  w_bytes [MAX_BYTES];

    // Split the held digits into bytes, byte k holding digits 2k and 2k+1.
    for (genvar k = 0; k < MAX_BYTES; k++) begin : g_bytes
        assign w_bytes[k] = r_digits[k*BYTE_W +: BYTE_W];
    end

    // Byte k counts from the least significant end; normal order runs downwards.
    assign w_pair = r_swap ? r_idx : r_n - COUNT_W'(1) - r_idx;
    assign w_last = (r_idx == r_n - COUNT_W'(1));
    assign w_fire = o_out.valid && o_out.ready;
    assign o_free = !r_active || (w_fire && w_last);

    assign o_out.valid    = r_active;
    assign o_out.bcd_byte = w_bytes[w_pair];
    assign o_out.last     = w_last;

    // Step through the bytes; a new conversion may load as the last byte leaves.
    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        if (i_load.load) begin
            n_active = (i_load.count != '0);
            n_idx    = '0;
        end else if (w_fire) begin
            if (w_last) begin
                n_active = 1'b0;
            end
            n_idx = r_idx + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

    // Payload of the held conversion.
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_digits <= i_digits;
            r_n      <= i_load.count;
            r_swap   <= i_load.swap;
        end
    end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for binary_to_packed_bcd_core: a directed table, then random values.
// Every packed BCD byte is checked against the bytes typed into the table or a predictor of the same conversion.
// Depends on b2bcd_pkg, b2bcd_in_if, b2bcd_out_if and the converter core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b2bcd_pkg::*;

    localparam int LATENCY_WAIT = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 410;

    // One expected output item: a packed BCD byte and its end-of-value flag.
    typedef struct packed {
        logic [BYTE_W-1:0] bcd_byte;
        logic              last;
    } t_bcd_item;

    // One row of the directed table. Where typed is set, seq holds the bytes in
    // order of emission, the first byte at the top of the byte_count-byte group.
    typedef struct packed {
        logic [COUNT_W-1:0]          count;
        logic                        swap;
        logic [VALUE_W-1:0]          value;
        logic                        typed;
        logic [MAX_BYTES*BYTE_W-1:0] seq;
    } t_dir_row;

    localparam int DIR_ROWS = 23;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{4'd10, 1'b0, 64'd0,                    1'b1, 80'h0},
        '{4'd10, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,  1'b1, 80'h18446744073709551615},
        '{4'd10, 1'b0, 64'd1,                    1'b1, 80'h1},
        '{4'd10, 1'b0, 64'd9999999999999999999,  1'b1, 80'h09999999999999999999},
        '{4'd10, 1'b0, 64'd10000000000000000000, 1'b1, 80'h10000000000000000000},
        '{4'd10, 1'b0, 64'h8000_0000_0000_0000,  1'b0, 80'h0},
        '{4'd10, 1'b0, 64'h5555_5555_5555_5555,  1'b0, 80'h0},
        '{4'd10, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA,  1'b0, 80'h0},
        '{4'd10, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,  1'b1, 80'h15165509370744674418},
        '{4'd10, 1'b1, 64'd1234567890123456789,  1'b0, 80'h0},
        '{4'd10, 1'b1, 64'd1,                    1'b1, 80'h01000000000000000000},
        '{4'd1,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF,  1'b1, 80'h15},
        '{4'd1,  1'b0, 64'd99,                   1'b1, 80'h99},
        '{4'd1,  1'b0, 64'd100,                  1'b1, 80'h00},
        '{4'd1,  1'b1, 64'd12345,                1'b1, 80'h45},
        '{4'd0,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF,  1'b1, 80'h0},
        '{4'd0,  1'b1, 64'd7,                    1'b0, 80'h0},
        '{4'd5,  1'b0, 64'd12345,                1'b1, 80'h0000012345},
        '{4'd5,  1'b1, 64'd12345,                1'b1, 80'h4523010000},
        '{4'd15, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,  1'b1, 80'h18446744073709551615},
        '{4'd15, 1'b1, 64'd42,                   1'b0, 80'h0},
        '{4'd11, 1'b0, 64'd12345678901234567890, 1'b1, 80'h12345678901234567890},
        '{4'd2,  1'b1, 64'd123456,               1'b0, 80'h0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    b2bcd_in_if  in_ch ();
    b2bcd_out_if out_ch ();

    binary_to_packed_bcd_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Configuration as the predictor sees it; changed only while the block is idle.
    logic [COUNT_W-1:0] cfg_count = 4'd10;
    logic               cfg_swap  = 1'b0;

    // Expectation carried alongside the value currently offered on the input.
    logic                        cur_typed = 1'b0;
    logic [MAX_BYTES*BYTE_W-1:0] cur_seq   = '0;

    t_bcd_item bcd_expect_q [$];
    int        mismatch_count = 0;
    int        readback_errs  = 0;

    logic steady      = 1'b0;
    logic pressure_go = 1'b0;
    logic hold_off    = 1'b0;
    int   stall_left  = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit, well above the slowest legal run.
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Number of bytes per value, with the count saturated at the maximum.
    function automatic int bytes_per_value();
        return (cfg_count > MAX_BYTES) ? MAX_BYTES : int'(cfg_count);
    endfunction

    // Predict the packed BCD bytes of one value and queue them in order of emission.
    task automatic queue_bcd_bytes(input logic [VALUE_W-1:0] v);
        logic [NUM_DIGITS*DIGIT_W-1:0] dec;
        logic [VALUE_W-1:0]            rest;
        int                            n;
        int                            p;
        rest = v;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            dec[DIGIT_W*k +: DIGIT_W] = DIGIT_W'(rest % 64'd10);
            rest = rest / 64'd10;
        end
        n = bytes_per_value();
        for (int i = 0; i < n; i++) begin
            p = cfg_swap ? i : n - 1 - i;
            bcd_expect_q.push_back('{dec[BYTE_W*p +: BYTE_W], i == n - 1});
        end
    endtask

    // Queue bytes typed into the directed table.
    task automatic queue_typed_bytes(input logic [MAX_BYTES*BYTE_W-1:0] seq);
        int n;
        n = bytes_per_value();
        for (int i = 0; i < n; i++) begin
            bcd_expect_q.push_back('{seq[BYTE_W*(n-1-i) +: BYTE_W], i == n - 1});
        end
    endtask

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // Random value, biased towards decimal boundaries and the ends of the range.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p10;
        int                 k;
        v   = {$urandom, $urandom};
        k   = $urandom_range(0, 19);
        p10 = 64'd1;
        repeat (k) p10 = p10 * 64'd10;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return v;
            4:          return v % p10;
            5:          return p10;
            6:          return p10 - 64'd1;
            7:          return p10 + 64'($urandom_range(0, 9));
            8:          return ~64'd0 - 64'($urandom_range(0, 999));
            default:    return 64'($urandom_range(0, 9999));
        endcase
    endfunction

    // Check output items against the oldest expectation, and predict each accepted value.
    always @(posedge i_clk) begin : check_outputs
        t_bcd_item want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (bcd_expect_q.size() == 0) begin
                    $display("%0t: unexpected item, bcd_byte %02h last %0b", $realtime,
                             out_ch.bcd_byte, out_ch.last);
                    mismatch_count++;
                end else begin
                    want = bcd_expect_q.pop_front();
                    if (out_ch.bcd_byte !== want.bcd_byte) begin
                        $display("%0t: bcd_byte expected %02h, got %02h", $realtime,
                                 want.bcd_byte, out_ch.bcd_byte);
                        mismatch_count++;
                    end
                    if (out_ch.last !== want.last) begin
                        $display("%0t: last expected %0b, got %0b", $realtime,
                                 want.last, out_ch.last);
                        mismatch_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (cur_typed) begin
                    queue_typed_bytes(cur_seq);
                end else begin
                    queue_bcd_bytes(in_ch.value);
                end
            end
        end
    end

    // Output side: random stalls, steady stretches and the long hold-off.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else if (!steady && $urandom_range(0, 99) < 30) begin
                out_ch.ready <= 1'b0;
                stall_left = idle_len() - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Long hold-off of the output, so that the block fills up and stalls its input.
    initial begin
        wait (pressure_go);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    // Offer one value and wait until it is accepted. Called and returns at a falling edge.
    task automatic send_value(input logic [VALUE_W-1:0] v, input logic typed,
                              input logic [MAX_BYTES*BYTE_W-1:0] seq);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        cur_typed   <= typed;
        cur_seq     <= seq;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
    endtask

    // Wait until every expected item has arrived and the block has settled.
    task automatic wait_idle();
        do @(posedge i_clk); while (bcd_expect_q.size() != 0);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_transfer(input logic wr, input logic idx, input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write a register, read it back and check the stored value.
    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] stored;
        logic [PDATA_W-1:0] rdata;
        stored = (idx == REG_BYTE_COUNT) ? (data & 32'hF) : (data & 32'h1);
        apb_transfer(1'b1, idx, data, rdata);
        apb_transfer(1'b0, idx, '0, rdata);
        if (rdata !== stored) begin
            $display("%0t: register %0d read back expected %08h, got %08h", $realtime,
                     idx, stored, rdata);
            readback_errs++;
        end
    endtask

    // Set both registers; the upper bits of the write data are noise.
    task automatic set_config(input logic [COUNT_W-1:0] count, input logic swap);
        write_reg(REG_BYTE_COUNT, {28'($urandom_range(0, 32'h0FFF_FFFF)), count});
        write_reg(REG_SWAP_ORDER, {31'($urandom_range(0, 32'h7FFF_FFFF)), swap});
        cfg_count = count;
        cfg_swap  = swap;
    endtask

    // Reset, directed table, then random phases with fresh settings.
    initial begin
        int                 random_sent;
        int                 phase;
        int                 n_items;
        int                 r;
        logic [COUNT_W-1:0] count;
        logic               swap;

        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table; the first rows run on the settings left by reset.
        for (int row = 0; row < DIR_ROWS; row++) begin
            if (dir_tab[row].count != cfg_count || dir_tab[row].swap != cfg_swap) begin
                in_ch.valid <= 1'b0;
                wait_idle();
                set_config(dir_tab[row].count, dir_tab[row].swap);
            end
            send_value(dir_tab[row].value, dir_tab[row].typed, dir_tab[row].seq);
        end
        in_ch.valid <= 1'b0;

        // Random phases: full count first, then a single byte, then the hold-off phase, then random counts.
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0, 2:    count = 4'd10;
                1:       count = 4'd1;
                default: begin
                    r = $urandom_range(0, 19);
                    if (r < 2) begin
                        count = 4'd0;
                    end else if (r < 5) begin
                        count = COUNT_W'($urandom_range(11, 15));
                    end else begin
                        count = COUNT_W'($urandom_range(1, 10));
                    end
                end
            endcase
            swap = 1'($urandom_range(0, 1));
            wait_idle();
            set_config(count, swap);
            steady <= (phase % 4 == 3);
            if (phase == 2) begin
                pressure_go <= 1'b1;
            end
            n_items = (count == 0) ? 8 : $urandom_range(35, 55);
            for (int i = 0; i < n_items && random_sent < RANDOM_ITEMS; i++) begin
                send_value(random_value(), 1'b0, '0);
                random_sent++;
            end
            in_ch.valid <= 1'b0;
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0 && readback_errs == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/b2bcd_pkg.sv
hdl/b2bcd_in_if.sv
hdl/b2bcd_out_if.sv
hdl/b2bcd_cell.sv
hdl/b2bcd_out.sv
hdl/binary_to_packed_bcd_core.sv
sim/testbench.sv
